// ----- rtl/gfys_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gfys_pkg
// Shared types and constants of the grouped Fisher-Yates shuffle block.
// ----------------------------------------------------------------------------
package gfys_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int RAND_W      = 32;
    localparam int PROD_W      = RAND_W + SIZE_W;
    localparam int CLR_W       = IDX_W - 1;

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_ADDR,
        ST_SWAP,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear;
        logic calc;
        logic mul;
        logic advance;
    } idx_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] tgt;
        logic             last;
    } idx_stat_t;

endpackage : gfys_pkg
`default_nettype wire

// ----- rtl/gfys_perm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gfys_perm_ram
// Permutation store: two ports, each reads or writes one entry per cycle,
// read data registered.
// ----------------------------------------------------------------------------
module gfys_perm_ram
    import gfys_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             a_en,
    input  wire logic             a_we,
    input  wire logic [IDX_W-1:0] a_addr,
    input  wire logic [IDX_W-1:0] a_wdata,
    output logic      [IDX_W-1:0] a_rdata,
    input  wire logic             b_en,
    input  wire logic             b_we,
    input  wire logic [IDX_W-1:0] b_addr,
    input  wire logic [IDX_W-1:0] b_wdata,
    output logic      [IDX_W-1:0] b_rdata
);

    logic [IDX_W-1:0] mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (a_en) begin
            if (a_we) begin
                mem[a_addr] <= a_wdata;
            end else begin
                a_rdata <= mem[a_addr];
            end
        end
        if (b_en) begin
            if (b_we) begin
                mem[b_addr] <= b_wdata;
            end else begin
                b_rdata <= mem[b_addr];
            end
        end
    end

endmodule : gfys_perm_ram
`default_nettype wire

// ----- rtl/gfys_index_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gfys_index_unit
// Position and group base registers, local index and scaled random target.
// ----------------------------------------------------------------------------
module gfys_index_unit
    import gfys_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire idx_ctrl_t         ctrl,
    input  wire logic [RAND_W-1:0] rand_word,
    input  wire logic              group_begin,
    input  wire logic [SIZE_W-1:0] size,
    output idx_stat_t              stat
);

    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]  local_reg, local_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  pos_eff;
    logic [IDX_W-1:0]  base_eff;
    logic [PROD_W-1:0] prod;
    logic              last;

    always_comb begin
        pos_eff = (SIZE_W'(pos_reg) >= size) ? '0 : pos_reg;
        if (group_begin || pos_eff == '0 || base_reg > pos_eff) begin
            base_eff = pos_eff;
        end else begin
            base_eff = base_reg;
        end
        prod = PROD_W'(rand_word) * PROD_W'(SIZE_W'(local_reg) + SIZE_W'(1));
        last = (SIZE_W'(pos_reg) + SIZE_W'(1)) >= size;
    end

    always_comb begin
        pos_next   = pos_reg;
        base_next  = base_reg;
        local_next = local_reg;
        j_next     = j_reg;
        if (ctrl.clear) begin
            pos_next  = '0;
            base_next = '0;
        end else if (ctrl.calc) begin
            pos_next   = pos_eff;
            base_next  = base_eff;
            local_next = pos_eff - base_eff;
        end else if (ctrl.mul) begin
            j_next = prod[RAND_W+IDX_W-1:RAND_W];
        end else if (ctrl.advance) begin
            pos_next = last ? '0 : pos_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            base_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        local_reg <= local_next;
        j_reg     <= j_next;
    end

    assign stat.pos  = pos_reg;
    assign stat.tgt  = base_reg + j_reg;
    assign stat.last = last;

endmodule : gfys_index_unit
`default_nettype wire

// ----- rtl/grouped_fisher_yates_shuffle.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_fisher_yates_shuffle
// Permutation store shuffled in place, one swap per step transfer, within
// label groups.
//
// Input channel s_*: s_tuser carries the command and the group start flag,
// s_tdata the random word and the read index. Output channel m_*: one
// transfer per input transfer, read value in m_tdata, end of pass on m_tlast.
// cfg_wr_en/cfg_wr_data write the permutation size at any idle moment.
// A step runs through compute of position and group base, one 32x11
// multiply, a read of both entries and the swap write, all on the two
// ports of the store.
// After aresetn and for a reset command, the store is swept back to identity
// at two entries a cycle, with s_tready low. The reset command's result
// follows the sweep.
// A held result sits in the output register; the next input transfer is
// still accepted and the block holds before writing its result until
// m_tready takes the previous one.
// ----------------------------------------------------------------------------
module grouped_fisher_yates_shuffle
    import gfys_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data, // perm_size
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,     // rand_word[31:0], read_index[41:32]
    input  wire logic [2:0]        s_tuser,     // cmd[1:0], group_begin[2]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,     // read_value[9:0]
    output logic                   m_tlast      // pass_done
);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [RAND_W-1:0] rand_reg, rand_next;
    logic              gb_reg, gb_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              done_reg, done_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_value_reg, m_value_next;
    logic              m_last_reg, m_last_next;

    logic              s_fire;
    logic              out_free;
    logic              clr_last;
    logic [SIZE_W-1:0] size_eff;
    idx_ctrl_t         idx_ctrl;
    idx_stat_t         idx_stat;

    logic              a_en, a_we, b_en, b_we;
    logic [IDX_W-1:0]  a_addr, a_wdata, a_rdata;
    logic [IDX_W-1:0]  b_addr, b_wdata, b_rdata;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign clr_last = clr_cnt_reg == '1;

    always_comb begin
        if (size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end else if (size_reg > SIZE_W'(MAX_ENTRIES)) begin
            size_eff = SIZE_W'(MAX_ENTRIES);
        end else begin
            size_eff = size_reg;
        end
    end

    gfys_perm_ram u_ram (
        .aclk    (aclk),
        .a_en    (a_en),
        .a_we    (a_we),
        .a_addr  (a_addr),
        .a_wdata (a_wdata),
        .a_rdata (a_rdata),
        .b_en    (b_en),
        .b_we    (b_we),
        .b_addr  (b_addr),
        .b_wdata (b_wdata),
        .b_rdata (b_rdata)
    );

    gfys_index_unit u_idx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (idx_ctrl),
        .rand_word   (rand_reg),
        .group_begin (gb_reg),
        .size        (size_eff),
        .stat        (idx_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = (cmd_reg == CMD_RESET) ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (cmd_t'(s_tuser[1:0]))
                        CMD_STEP:  state_next = ST_CALC;
                        CMD_READ:  state_next = ST_READ;
                        CMD_RESET: state_next = ST_CLEAR;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_CALC:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_SWAP;
            ST_SWAP:   state_next = ST_RESULT;
            ST_READ:   state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        idx_ctrl = '0;
        a_en     = 1'b0;
        a_we     = 1'b0;
        a_addr   = idx_stat.pos;
        a_wdata  = b_rdata;
        b_en     = 1'b0;
        b_we     = 1'b0;
        b_addr   = idx_stat.tgt;
        b_wdata  = a_rdata;
        case (state_reg)
            ST_CLEAR: begin
                a_en     = 1'b1;
                a_we     = 1'b1;
                a_addr   = {clr_cnt_reg, 1'b0};
                a_wdata  = {clr_cnt_reg, 1'b0};
                b_en     = 1'b1;
                b_we     = 1'b1;
                b_addr   = {clr_cnt_reg, 1'b1};
                b_wdata  = {clr_cnt_reg, 1'b1};
                idx_ctrl.clear = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_CALC: begin
                idx_ctrl.calc = 1'b1;
            end
            ST_MUL: begin
                idx_ctrl.mul = 1'b1;
            end
            ST_ADDR: begin
                a_en = 1'b1;
                b_en = 1'b1;
            end
            ST_SWAP: begin
                a_en = 1'b1;
                a_we = 1'b1;
                b_en = idx_stat.tgt != idx_stat.pos;
                b_we = 1'b1;
                idx_ctrl.advance = 1'b1;
            end
            ST_READ: begin
                a_en   = 1'b1;
                a_addr = ridx_reg;
            end
            default: begin
            end
        endcase
    end

    // data path registers
    always_comb begin
        cmd_next     = cmd_reg;
        size_next    = cfg_wr_en ? cfg_wr_data : size_reg;
        clr_cnt_next = (state_reg == ST_CLEAR) ? clr_cnt_reg + CLR_W'(1) : '0;
        rand_next    = rand_reg;
        gb_next      = gb_reg;
        ridx_next    = ridx_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        if (s_fire) begin
            cmd_next  = cmd_t'(s_tuser[1:0]);
            gb_next   = s_tuser[2];
            rand_next = s_tdata[RAND_W-1:0];
            ridx_next = s_tdata[RAND_W+IDX_W-1:RAND_W];
            done_next = 1'b0;
        end
        if (state_reg == ST_SWAP) begin
            done_next = idx_stat.last;
        end
        if (state_reg == ST_RESULT && out_free) begin
            m_valid_next = 1'b1;
            m_value_next = (cmd_reg == CMD_READ) ? a_rdata : '0;
            m_last_next  = (cmd_reg == CMD_STEP) && done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cmd_reg     <= CMD_NOP;
            size_reg    <= SIZE_W'(MAX_ENTRIES);
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            size_reg    <= size_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rand_reg    <= rand_next;
        gb_reg      <= gb_next;
        ridx_reg    <= ridx_next;
        done_reg    <= done_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - IDX_W){1'b0}}, m_value_reg};
    assign m_tlast  = m_last_reg;

endmodule : grouped_fisher_yates_shuffle
`default_nettype wire
